// File: sv/assert_macros.svh
// Assertion macros used by the scorer RTL.
// Depends on clk and rst_n being visible in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/hss_pkg.sv
// Package for the HMM sequence scorer: sizes, codes, cell control struct, Q multiply.
// Used by hss_cell and hmm_sequence_scorer.
`default_nettype none
package hss_pkg;

  localparam int STATES  = 8;
  localparam int SYMBOLS = 16;
  localparam int IDX_W   = (STATES > 1) ? $clog2(STATES) : 1;
  localparam int SYM_W   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int CNT_W   = $clog2(STATES + 1);
  localparam int ACC_W   = 32 + CNT_W;

  localparam logic [31:0] Q_ONE   = 32'hFFFF_FFFF;
  localparam logic [15:0] EXP_MAX = 16'hFFFF;

  localparam logic [1:0] FN_LOAD_T = 2'd0;
  localparam logic [1:0] FN_LOAD_E = 2'd1;
  localparam logic [1:0] FN_START  = 2'd2;
  localparam logic [1:0] FN_SYMBOL = 2'd3;

  localparam logic REG_SCORE_MODE  = 1'b0;
  localparam logic REG_STATES_USED = 1'b1;

  typedef struct packed {
    logic             issue;
    logic             rotate;
    logic             start;
    logic             clear_acc;
    logic             finish;
    logic             shl;
    logic             mode;
    logic             sym_ok;
    logic [IDX_W-1:0] step;
    logic [SYM_W-1:0] sym;
    logic [CNT_W-1:0] used_n;
  } cell_ctrl_t;

  function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {32'b0, a} * {32'b0, b};
    return p[63:32];
  endfunction

endpackage
`default_nettype wire

// File: sv/hmm_sequence_scorer.sv
// Top level of the HMM sequence scorer: control sequencer, ring of cells,
// score reduction and normalization. Depends on hss_pkg, hss_cell and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transfer: table
//   loads (func 0/1), sequence start (func 2) or an observed symbol (func 3).
//   Every item yields exactly one result transfer on out_valid/out_ready with
//   the running score mantissa, the exponent, its saturation flag and func.
//   Configuration writes (cfg_valid/cfg_ready, always ready) set score mode
//   (index 0) and states used (index 1); write them only while idle.
// Sequence of steps, one item at a time:
//   load or start: rotate the ring through all states to reduce the score,
//   then a normalize check and the output load.
//   symbol: issue over the source states, drain the multiply pipeline, finish,
//   reduce the ring, shift one normalization bit per cycle, a normalize check
//   and the output load. The input is ready again in the cycle after the output load.
// Reset: path vector holds all weight in state 0, exponent zero, mode
//   forward, states used 8. Tables are undefined until loaded.
// Stall: a finished result waits in the output register; the next item is
//   still taken and computed, then holds in its done state with in_ready low
//   until the waiting result has transferred.
`default_nettype none
`include "assert_macros.svh"
module hmm_sequence_scorer
  import hss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [2:0]  in_row_index,
  input  wire logic [3:0]  in_col_index,
  input  wire logic [31:0] in_table_value,
  input  wire logic [3:0]  in_symbol,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_score_mantissa,
  output logic [15:0]      out_score_exponent,
  output logic             out_exponent_saturated,
  output logic [1:0]       out_accepted_kind,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_UPDATE = 7'b0000010,
    ST_DRAIN  = 7'b0000100,
    ST_FINISH = 7'b0001000,
    ST_SCORE  = 7'b0010000,
    ST_NORM   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic [15:0]      exp_r, exp_nxt;
  logic [ACC_W-1:0] sacc_r, sacc_nxt, sum_cmb;
  logic [31:0]      score_r, score_nxt;
  logic             sat_r, sat_nxt;
  logic [1:0]       func_r;
  logic [3:0]       sym_r;
  logic             mode_r;
  logic [3:0]       used_r;
  logic [CNT_W-1:0] used_n;
  logic             out_valid_r;
  logic             in_fire, norm_go, out_load;
  cell_ctrl_t       ctrl;
  logic [31:0]      pv_out [STATES];
  logic [31:0]      head;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign head      = pv_out[0];

  // Clamp states used into two .. STATES.
  always_comb begin
    if (used_r < 4'd2) begin
      used_n = CNT_W'(2);
    end else if (int'(used_r) > STATES) begin
      used_n = CNT_W'(STATES);
    end else begin
      used_n = CNT_W'(used_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      used_r <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCORE_MODE:  mode_r <= cfg_data[0];
        REG_STATES_USED: used_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign norm_go = (func_r == FN_SYMBOL) && !sat_r && (score_r != 32'd0) &&
                   !score_r[31] && (exp_r != EXP_MAX);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // Next value of the running reduction: sum or maximum of the ring head.
  always_comb begin
    sum_cmb = sacc_r;
    if (step_r < used_n) begin
      if (mode_r) begin
        if (ACC_W'(head) > sacc_r) begin
          sum_cmb = ACC_W'(head);
        end
      end else begin
        sum_cmb = sacc_r + ACC_W'(head);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    exp_nxt        = exp_r;
    sacc_nxt       = sacc_r;
    score_nxt      = score_r;
    sat_nxt        = sat_r;
    ctrl           = '0;
    ctrl.mode      = mode_r;
    ctrl.used_n    = used_n;
    ctrl.step      = IDX_W'(step_r);
    ctrl.sym       = SYM_W'(sym_r);
    ctrl.sym_ok    = int'(sym_r) < SYMBOLS;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          step_nxt = '0;
          sacc_nxt = '0;
          if (in_func == FN_SYMBOL) begin
            ctrl.clear_acc = 1'b1;
            state_nxt      = ST_UPDATE;
          end else begin
            if (in_func == FN_START) begin
              ctrl.start = 1'b1;
              exp_nxt    = 16'd0;
            end
            state_nxt = ST_SCORE;
          end
        end
      end
      ST_UPDATE: begin
        ctrl.issue  = 1'b1;
        ctrl.rotate = 1'b1;
        step_nxt    = step_r + CNT_W'(1);
        if (step_r == CNT_W'(STATES - 1)) begin
          step_nxt  = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        step_nxt = step_r + CNT_W'(1);
        if (step_r == CNT_W'(2)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        ctrl.finish = 1'b1;
        step_nxt    = '0;
        sacc_nxt    = '0;
        state_nxt   = ST_SCORE;
      end
      ST_SCORE: begin
        ctrl.rotate = 1'b1;
        sacc_nxt    = sum_cmb;
        step_nxt    = step_r + CNT_W'(1);
        if (step_r == CNT_W'(STATES - 1)) begin
          sat_nxt   = sum_cmb > ACC_W'(Q_ONE);
          score_nxt = (sum_cmb > ACC_W'(Q_ONE)) ? Q_ONE : sum_cmb[31:0];
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        // Shift one bit per cycle until normalized or the exponent tops out.
        if (norm_go) begin
          ctrl.shl  = 1'b1;
          score_nxt = {score_r[30:0], 1'b0};
          exp_nxt   = exp_r + 16'd1;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      exp_r       <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      exp_r   <= exp_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sacc_r  <= sacc_nxt;
    score_r <= score_nxt;
    sat_r   <= sat_nxt;
    if (in_fire) begin
      func_r <= in_func;
      sym_r  <= in_symbol;
    end
    if (out_load) begin
      out_score_mantissa     <= score_r;
      out_score_exponent     <= exp_r;
      out_exponent_saturated <= (exp_r == EXP_MAX);
      out_accepted_kind      <= func_r;
    end
  end

  assign out_valid = out_valid_r;

  for (genvar g = 0; g < STATES; g++) begin : g_cell
    logic t_we, e_we;
    assign t_we = in_fire && (in_func == FN_LOAD_T) && (int'(in_col_index) == g) &&
                  (int'(in_row_index) < STATES);
    assign e_we = in_fire && (in_func == FN_LOAD_E) && (int'(in_row_index) == g) &&
                  (int'(in_col_index) < SYMBOLS);
    hss_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .cell_idx (IDX_W'(g)),
      .t_we     (t_we),
      .t_waddr  (IDX_W'(in_row_index)),
      .e_we     (e_we),
      .e_waddr  (SYM_W'(in_col_index)),
      .wdata    (in_table_value),
      .pv_in    (pv_out[(g + 1) % STATES]),
      .pv_out   (pv_out[g])
    );
  end

  `ASSERT_CLK(a_norm_step, ctrl.shl |=> (exp_r == $past(exp_r) + 16'd1), "exponent missed a step")
  `ASSERT_CLK(a_exp_sticky, exp_r == EXP_MAX && !ctrl.start |=> exp_r == EXP_MAX, "exp moved")
  `ASSERT_CLK(a_fire_busy, in_fire |=> !in_ready, "busy block stayed ready")

endmodule
`default_nettype wire

// File: sv/hss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module hss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/hss_cell.sv
// One destination-state cell: path value, ring link, transition column and
// emission row memories, multiply pipeline. Depends on hss_pkg and hss_ram.
`default_nettype none
module hss_cell
  import hss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire logic             t_we,
  input  wire logic [IDX_W-1:0] t_waddr,
  input  wire logic             e_we,
  input  wire logic [SYM_W-1:0] e_waddr,
  input  wire logic [31:0]      wdata,
  input  wire logic [31:0]      pv_in,
  output logic      [31:0]      pv_out
);

  logic [31:0]      pv_r, pv_d1_r, p1_r, p2_r, max_r;
  logic [ACC_W-1:0] acc_r;
  logic             val0_r, val1_r, val2_r;
  logic [IDX_W:0]   src_sum;
  logic [IDX_W-1:0] src;
  logic             src_ok;
  logic [31:0]      t_rdata, e_rdata, e_val, acc_sat, fin_val;

  // Source state currently held in this cell's ring slot.
  always_comb begin
    src_sum = {1'b0, cell_idx} + {1'b0, ctrl.step};
    if (src_sum >= (IDX_W+1)'(STATES)) begin
      src_sum = src_sum - (IDX_W+1)'(STATES);
    end
    src    = src_sum[IDX_W-1:0];
    src_ok = CNT_W'(src) < ctrl.used_n;
  end

  hss_ram #(.WIDTH(32), .DEPTH(STATES)) u_t_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(wdata),
    .raddr(src), .rdata(t_rdata)
  );

  hss_ram #(.WIDTH(32), .DEPTH(SYMBOLS)) u_e_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(wdata),
    .raddr(ctrl.sym), .rdata(e_rdata)
  );

  always_comb begin
    e_val   = ctrl.sym_ok ? e_rdata : 32'd0;
    acc_sat = (acc_r > ACC_W'(Q_ONE)) ? Q_ONE : acc_r[31:0];
    if (CNT_W'(cell_idx) >= ctrl.used_n) begin
      fin_val = 32'd0;
    end else if (ctrl.mode) begin
      fin_val = max_r;
    end else begin
      fin_val = qmul(acc_sat, e_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r   <= (cell_idx == '0) ? Q_ONE : 32'd0;
      val0_r <= 1'b0;
      val1_r <= 1'b0;
      val2_r <= 1'b0;
    end else begin
      val0_r <= ctrl.issue && src_ok;
      val1_r <= val0_r;
      val2_r <= val1_r;
      if (ctrl.start) begin
        pv_r <= (cell_idx == '0) ? Q_ONE : 32'd0;
      end else if (ctrl.finish) begin
        pv_r <= fin_val;
      end else if (ctrl.shl) begin
        pv_r <= {pv_r[30:0], 1'b0};
      end else if (ctrl.rotate) begin
        pv_r <= pv_in;
      end
    end
  end

  // Multiply pipeline: prev*T, then sum (forward) or *E and max (Viterbi).
  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      pv_d1_r <= pv_r;
    end
    p1_r <= qmul(pv_d1_r, t_rdata);
    p2_r <= qmul(p1_r, e_val);
    if (ctrl.clear_acc) begin
      acc_r <= '0;
      max_r <= 32'd0;
    end else begin
      if (val1_r) begin
        acc_r <= acc_r + ACC_W'(p1_r);
      end
      if (val2_r && (p2_r > max_r)) begin
        max_r <= p2_r;
      end
    end
  end

  assign pv_out = pv_r;

endmodule
`default_nettype wire
